// ===== rtl/fap_pkg.sv =====
package fap_pkg;

    // Pool geometry.
    localparam int PAGE_BYTES = 256;
    localparam int PAGE_COUNT = 256;

    // Derived widths.
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int ADDR_W     = $clog2(PAGE_COUNT);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int SIZE_W     = 17;
    localparam int NEED_W     = SIZE_W - PAGE_SHIFT + 1;
    localparam int RESULT_W   = 9;

    // Request codes.
    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    // Request item.
    typedef struct packed {
        t_action             action;
        logic [SIZE_W-1:0]   size_bytes;
        logic [7:0]          page_index;
    } t_item;

    // Result item.
    typedef struct packed {
        logic                status;
        logic [RESULT_W-1:0] result_page;
    } t_result;

    // Per-page marks as held in the page table.
    typedef struct packed {
        logic valid;
        logic is_start;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== rtl/fap_ram.sv =====
module fap_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/first_fit_page_allocator_unit.sv =====
// Channel  | Ports                       | Handshake
// ---------+-----------------------------+-------------------------------------
// request  | start, busy, i_item         | item taken when start & !busy
// result   | o_done, o_result            | one-cycle strobe, cannot be held off
//
// Allocate enters the scan state, scans the page table one page a cycle through the
// registered RAM read until a long enough run is found or the last page is checked,
// then marks the run one page a cycle. Free reads, then checks and writes, each page
// it checks, the page that stops the walk included. Clear, unused codes and zero or
// oversize allocations are answered straight from idle.
// Reset is synchronous: the sequencer idles and all per-page written flags clear,
// so every page reads free at once; no clearing pass is needed.
// The result strobe is not stalled; busy is high after acceptance until the strobe
// cycle, and stays low for items that are answered straight from idle.
module first_fit_page_allocator_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  fap_pkg::t_item    i_item,
    output logic              busy,
    output logic              o_done,
    output fap_pkg::t_result  o_result
);

    import fap_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SCAN     = 5'b00010,
        S_MARK     = 5'b00100,
        S_FREE_RD  = 5'b01000,
        S_FREE_CHK = 5'b10000
    } t_state;

    t_state              r_state,   n_state;
    logic [CNT_W-1:0]    r_idx,     n_idx;
    logic [ADDR_W-1:0]   r_chk,     n_chk;
    logic                r_chk_ok,  n_chk_ok;
    logic [NEED_W-1:0]   r_run,     n_run;
    logic [NEED_W-1:0]   r_need,    n_need;
    logic [CNT_W-1:0]    r_first,   n_first;
    logic [CNT_W-1:0]    r_end,     n_end;
    logic                r_head,    n_head;
    logic [PAGE_COUNT-1:0] r_written, n_written;
    logic                r_done,    n_done;
    t_result             r_result,  n_result;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_q;

    logic [NEED_W-1:0]   req_need;
    logic [NEED_W-1:0]   run_next;
    t_entry              chk_entry;
    t_entry              idx_entry;

    // Page table: valid and start marks, one entry per page.
    fap_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PAGE_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // Pages needed, rounded up to whole pages.
    assign req_need = NEED_W'(i_item.size_bytes >> PAGE_SHIFT)
                    + NEED_W'(|(i_item.size_bytes & SIZE_W'(PAGE_BYTES - 1)));

    // An entry never written since reset or clear reads as free.
    assign chk_entry = r_written[r_chk] ? t_entry'(ram_q) : t_entry'('0);
    assign idx_entry = r_written[r_idx[ADDR_W-1:0]] ? t_entry'(ram_q) : t_entry'('0);

    // Length of the free run ending at the page under check.
    assign run_next = chk_entry.valid ? '0 : r_run + NEED_W'(1);

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_chk     = r_chk;
        n_chk_ok  = r_chk_ok;
        n_run     = r_run;
        n_need    = r_need;
        n_first   = r_first;
        n_end     = r_end;
        n_head    = r_head;
        n_written = r_written;
        n_done    = 1'b0;
        n_result  = r_result;
        ram_we    = 1'b0;
        ram_waddr = r_idx[ADDR_W-1:0];
        ram_wdata = '0;
        ram_raddr = r_idx[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_item.action)
                        ACT_ALLOC: begin
                            if (req_need == '0 || req_need > NEED_W'(PAGE_COUNT)) begin
                                n_done   = 1'b1;
                                n_result = '{status: 1'b1, result_page: '0};
                            end else begin
                                n_need   = req_need;
                                n_idx    = '0;
                                n_chk_ok = 1'b0;
                                n_run    = '0;
                                n_state  = S_SCAN;
                            end
                        end
                        ACT_FREE: begin
                            if ({1'b0, i_item.page_index} >= CNT_W'(PAGE_COUNT)) begin
                                n_done   = 1'b1;
                                n_result = '{status: 1'b0,
                                             result_page: RESULT_W'(i_item.page_index)};
                            end else begin
                                n_idx   = CNT_W'(i_item.page_index);
                                n_head  = 1'b1;
                                n_state = S_FREE_RD;
                            end
                        end
                        ACT_CLEAR: begin
                            n_written = '0;
                            n_done    = 1'b1;
                            n_result  = '{status: 1'b0, result_page: '0};
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_result = '{status: 1'b0, result_page: '0};
                        end
                    endcase
                end
            end

            // Read one page a cycle; check the page read in the previous cycle.
            S_SCAN: begin
                if (r_idx < CNT_W'(PAGE_COUNT)) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                n_chk    = r_idx[ADDR_W-1:0];
                n_chk_ok = (r_idx < CNT_W'(PAGE_COUNT));
                if (r_chk_ok) begin
                    n_run = run_next;
                    if (run_next == r_need) begin
                        n_first = CNT_W'({1'b0, r_chk}) + CNT_W'(1) - CNT_W'(r_need);
                        n_end   = CNT_W'({1'b0, r_chk}) + CNT_W'(1);
                        n_idx   = CNT_W'({1'b0, r_chk}) + CNT_W'(1) - CNT_W'(r_need);
                        n_state = S_MARK;
                    end else if (r_chk == ADDR_W'(PAGE_COUNT - 1)) begin
                        n_done   = 1'b1;
                        n_result = '{status: 1'b1, result_page: '0};
                        n_state  = S_IDLE;
                    end
                end
            end

            // Mark the run in use, the first page also as a start.
            S_MARK: begin
                ram_we    = 1'b1;
                ram_wdata = ENTRY_W'(t_entry'{valid: 1'b1, is_start: (r_idx == r_first)});
                n_written[r_idx[ADDR_W-1:0]] = 1'b1;
                n_idx = r_idx + CNT_W'(1);
                if (r_idx + CNT_W'(1) == r_end) begin
                    n_done   = 1'b1;
                    n_result = '{status: 1'b0, result_page: RESULT_W'(r_first)};
                    n_state  = S_IDLE;
                end
            end

            S_FREE_RD: begin
                n_state = S_FREE_CHK;
            end

            // Release pages while they are in use and not the start of another run.
            S_FREE_CHK: begin
                if (idx_entry.valid && (r_head || !idx_entry.is_start)) begin
                    ram_we    = 1'b1;
                    ram_wdata = '0;
                    n_written[r_idx[ADDR_W-1:0]] = 1'b1;
                    n_head = 1'b0;
                    if (r_idx + CNT_W'(1) == CNT_W'(PAGE_COUNT)) begin
                        n_done   = 1'b1;
                        n_result = '{status: 1'b0, result_page: RESULT_W'(PAGE_COUNT)};
                        n_state  = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = S_FREE_RD;
                    end
                end else begin
                    // The requested page loses its start mark even if nothing is walked.
                    if (r_head && idx_entry.is_start) begin
                        ram_we    = 1'b1;
                        ram_wdata = '0;
                        n_written[r_idx[ADDR_W-1:0]] = 1'b1;
                    end
                    n_done   = 1'b1;
                    n_result = '{status: 1'b0, result_page: RESULT_W'(r_idx)};
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_written <= '0;
            r_chk_ok  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_done    <= n_done;
            r_written <= n_written;
            r_chk_ok  <= n_chk_ok;
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_chk    <= n_chk;
        r_run    <= n_run;
        r_need   <= n_need;
        r_first  <= n_first;
        r_end    <= n_end;
        r_head   <= n_head;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== tb/sv/tb_first_fit_page_allocator_unit.sv =====
`timescale 1ns / 100ps

import fap_pkg::*;

// Keeps a private copy of the page table, works out the result of every
// accepted item and checks the results of the block against it in order.
class page_table_scoreboard;
    bit            in_use   [PAGE_COUNT];
    bit            run_head [PAGE_COUNT];
    t_result       expected_q [$];
    int unsigned   mismatches;

    function new();
        wipe_table();
        mismatches = 0;
    endfunction

    function void wipe_table();
        foreach (in_use[i]) begin
            in_use[i]   = 1'b0;
            run_head[i] = 1'b0;
        end
    endfunction

    task report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    function int pending();
        return expected_q.size();
    endfunction

    // Picks the first page of a live allocation, or any page when none is live.
    function logic [7:0] pick_run_head();
        int heads [$];
        foreach (run_head[i])
            if (run_head[i])
                heads.push_back(i);
        if (heads.size() == 0)
            return 8'($urandom_range(0, PAGE_COUNT - 1));
        return 8'(heads[$urandom_range(0, heads.size() - 1)]);
    endfunction

    // Works out the result of one accepted item and updates the table.
    function void note_request(t_item it);
        t_result     exp_res;
        int unsigned need;
        int unsigned run;
        int          pg;
        int          found;
        exp_res = '0;
        case (it.action)
            ACT_ALLOC: begin
                need = (int'(it.size_bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
                found = -1;
                if (it.size_bytes != 0 && need <= PAGE_COUNT) begin
                    // First fit: the earliest window of free pages that is long enough.
                    run = 0;
                    pg = 0;
                    while (pg < PAGE_COUNT && found < 0) begin
                        if (in_use[pg])
                            run = 0;
                        else
                            run++;
                        if (run == need)
                            found = pg + 1 - int'(need);
                        pg++;
                    end
                end
                if (found < 0) begin
                    exp_res.status = 1'b1;
                end else begin
                    run_head[found] = 1'b1;
                    for (int i = found; i < found + int'(need); i++)
                        in_use[i] = 1'b1;
                    exp_res.result_page = RESULT_W'(found);
                end
            end
            ACT_FREE: begin
                pg = int'(it.page_index);
                if (pg < PAGE_COUNT) begin
                    run_head[pg] = 1'b0;
                    // Walk up while pages are in use and no new allocation begins.
                    while (pg < PAGE_COUNT && in_use[pg] && !run_head[pg]) begin
                        in_use[pg] = 1'b0;
                        pg++;
                    end
                end
                exp_res.result_page = RESULT_W'(pg);
            end
            ACT_CLEAR: begin
                wipe_table();
            end
            default: begin
            end
        endcase
        expected_q.push_back(exp_res);
    endfunction

    // Compares one result with the oldest expectation.
    task check_result(t_result got);
        t_result exp_res;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result %0d/%0d with nothing expected",
                                      got.status, got.result_page));
        end else begin
            exp_res = expected_q.pop_front();
            if (got.status !== exp_res.status)
                report_mismatch($sformatf("status %b, expected %b",
                                          got.status, exp_res.status));
            if (got.result_page !== exp_res.result_page)
                report_mismatch($sformatf("result_page %0d, expected %0d",
                                          got.result_page, exp_res.result_page));
        end
    endtask
endclass

module tb_first_fit_page_allocator_unit;

    localparam t_action ACT_UNUSED   = t_action'(2'd3);
    localparam int      RANDOM_ITEMS = 400;
    localparam int      SETTLE_CYCLES = 20;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   i_item  = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    page_table_scoreboard sb = new();

    first_fit_page_allocator_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Results are checked before a new item is noted, as both may fall on one edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done !== 1'b0)
                sb.check_result(o_result);
            if (start && !busy)
                sb.note_request(i_item);
        end
    end

    function automatic t_item make_item(t_action act, int unsigned size, int unsigned page);
        t_item it;
        it.action     = act;
        it.size_bytes = SIZE_W'(size);
        it.page_index = 8'(page);
        return it;
    endfunction

    // Offers one item after an optional gap and returns once it is accepted.
    task automatic send_item(t_item it, int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
    endtask

    // Holds the request side off until every outstanding result has come.
    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Gap lengths: mostly short, a few long, none at all in quiet stretches.
    function automatic int unsigned pick_gap(bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 40)
            return 0;
        if (r < 75)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 80);
    endfunction

    // Byte sizes: mostly a few pages, some larger, a few zero or oversize.
    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 0;
        if (r < 7)
            return $urandom_range(PAGE_COUNT * PAGE_BYTES + 1, (1 << SIZE_W) - 1);
        if (r < 11)
            return $urandom_range(16384, PAGE_COUNT * PAGE_BYTES);
        if (r < 35)
            return $urandom_range(1, 16384);
        return $urandom_range(1, 2048);
    endfunction

    // Ends the run if the block stops answering.
    initial begin
        #5_000_000;
        $display("tb_first_fit_page_allocator_unit NOT OK");
        $finish;
    end

    initial begin
        t_item       directed_q [$];
        t_item       it;
        int unsigned r;
        bit          quiet;

        // Hold the synchronous reset, then release it.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items: sizes at the edges, frees of odd pages, a full pool.
        directed_q = '{
            make_item(ACT_ALLOC, 0, 0),
            make_item(ACT_ALLOC, 1, 255),
            make_item(ACT_ALLOC, 256, 0),
            make_item(ACT_ALLOC, 257, 0),
            make_item(ACT_FREE, 0, 3),
            make_item(ACT_FREE, 0, 2),
            make_item(ACT_FREE, 0, 10),
            make_item(ACT_ALLOC, 65537, 0),
            make_item(ACT_ALLOC, 131071, 255),
            make_item(ACT_UNUSED, 131071, 255),
            make_item(ACT_CLEAR, 131071, 255),
            make_item(ACT_ALLOC, 65536, 0),
            make_item(ACT_ALLOC, 1, 0),
            make_item(ACT_FREE, 0, 0),
            make_item(ACT_ALLOC, 65280, 0),
            make_item(ACT_ALLOC, 256, 0),
            make_item(ACT_FREE, 0, 255),
            make_item(ACT_FREE, 0, 255),
            make_item(ACT_CLEAR, 0, 0),
            make_item(ACT_ALLOC, 512, 0),
            make_item(ACT_ALLOC, 512, 0),
            make_item(ACT_ALLOC, 512, 0),
            make_item(ACT_FREE, 0, 2),
            make_item(ACT_ALLOC, 768, 0),
            make_item(ACT_ALLOC, 511, 0)
        };
        foreach (directed_q[i])
            send_item(directed_q[i], (i % 3 == 0) ? 0 : i % 4);
        wait_for_drain();

        // Random items: mostly allocations and frees of live runs, with noise.
        quiet = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) begin
                wait_for_drain();
                repeat ($urandom_range(0, 5)) @(posedge i_clk);
            end
            it = make_item(ACT_ALLOC, $urandom_range(0, (1 << SIZE_W) - 1),
                           $urandom_range(0, 255));
            r = $urandom_range(0, 99);
            if (r < 50) begin
                it.size_bytes = SIZE_W'(pick_size());
            end else if (r < 92) begin
                it.action = ACT_FREE;
                if ($urandom_range(0, 3) != 0)
                    it.page_index = sb.pick_run_head();
            end else if (r < 96) begin
                it.action = ACT_CLEAR;
            end else begin
                it.action = ACT_UNUSED;
            end
            send_item(it, pick_gap(quiet));
        end

        // Let every result come, then watch a little longer for stray strobes.
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("tb_first_fit_page_allocator_unit OK");
        else
            $display("tb_first_fit_page_allocator_unit NOT OK");
        $finish;
    end

endmodule
